// ----- rtl/core/slex_pkg.sv -----
// Shared types, token codes and keyword tables for the script lexer.
// No dependencies; every module of the lexer imports this package.
package slex_pkg;

	typedef logic [3:0] token_kind_t;

	localparam token_kind_t KIND_COMMAND     = 4'd0;
	localparam token_kind_t KIND_NUMFUNC     = 4'd1;
	localparam token_kind_t KIND_STRFUNC     = 4'd2;
	localparam token_kind_t KIND_NUMBER_END  = 4'd3;
	localparam token_kind_t KIND_STRING_END  = 4'd4;
	localparam token_kind_t KIND_OPERATOR    = 4'd5;
	localparam token_kind_t KIND_UNKNOWN     = 4'd6;
	localparam token_kind_t KIND_BAD_SYMBOL  = 4'd7;
	localparam token_kind_t KIND_UNTERM_STR  = 4'd8;
	localparam token_kind_t KIND_LITERAL     = 4'd9;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_WORD   = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_STRING = 2'd3
	} lex_mode_t;

	localparam int unsigned TABLE_WORDS = 11;
	localparam int unsigned KW_MAX_LEN  = 5;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [7:0]  CHAR_NL   = 8'd10;
	localparam logic [7:0]  CHAR_QUOTE = "\"";
	localparam logic [7:0]  CHAR_DOT  = ".";

	// keyword text, padded with zero bytes past each word's length
	localparam logic [7:0] KW_TEXT [TABLE_WORDS][KW_MAX_LEN] = '{
		'{"p", "r", "i", "n", "t"},
		'{"s", "i", "n", 8'd0, 8'd0},
		'{"c", "o", "s", 8'd0, 8'd0},
		'{"t", "a", "n", 8'd0, 8'd0},
		'{"c", "d", "b", "l", 8'd0},
		'{"p", "o", "w", 8'd0, 8'd0},
		'{"a", "t", "a", "n", 8'd0},
		'{"l", "e", "n", 8'd0, 8'd0},
		'{"l", "e", "f", "t", 8'd0},
		'{"m", "i", "d", 8'd0, 8'd0},
		'{"r", "i", "g", "h", "t"}
	};

	localparam logic [2:0] KW_LEN [TABLE_WORDS] = '{
		3'd5, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd5
	};

	localparam token_kind_t KW_CLASS [TABLE_WORDS] = '{
		KIND_COMMAND, KIND_NUMFUNC, KIND_NUMFUNC, KIND_NUMFUNC, KIND_NUMFUNC,
		KIND_NUMFUNC, KIND_NUMFUNC, KIND_NUMFUNC, KIND_STRFUNC, KIND_STRFUNC,
		KIND_STRFUNC
	};

	typedef struct packed {
		token_kind_t kind;
		logic [3:0]  index;
		logic [7:0]  lit;
	} lex_result_t;

	// one queue entry: all results caused by one accepted beat
	typedef struct packed {
		lex_result_t res_a;
		lex_result_t res_b;
		logic        two;
		logic [15:0] line;
		logic [15:0] col;
	} lex_entry_t;

endpackage

// ----- rtl/core/slex_front.sv -----
// Front end of the script lexer: accepts text beats, tracks mode, keyword mask
// and line/column, and pushes one entry per beat that yields tokens. Uses slex_pkg.
module slex_front #(
	parameter int unsigned KEYWORD_COUNT = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          text_byte_in,
	input  logic                end_of_text,
	input  logic                queue_full,
	output logic                push_valid,
	output slex_pkg::lex_entry_t push_entry
);
	import slex_pkg::*;

	localparam int unsigned KwUsed =
		(KEYWORD_COUNT < TABLE_WORDS) ? KEYWORD_COUNT : TABLE_WORDS;

	lex_mode_t         mode_q, mode_d;
	logic [KwUsed-1:0] cand_q, cand_d;
	logic [2:0]        wlen_q, wlen_d;
	logic [15:0]       line_q, line_d, col_q, col_d;
	logic              halted_q, halted_d;

	logic              accept;
	logic [7:0]        b;
	logic              is_letter, is_digit, is_space, is_op;
	logic [KwUsed-1:0] narrow_cur, narrow_first;
	logic              fw_hit;
	logic [3:0]        fw_idx;
	lex_result_t       fw_res;
	logic              id_emit, id_halt;
	lex_mode_t         id_mode;
	lex_result_t       id_res;
	logic [15:0]       cnt_line, cnt_col;

	// step plan
	lex_result_t       r0, r1;
	logic [1:0]        n;
	logic              halt, wfirst, wnext, flush;
	lex_mode_t         mode_n;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign b        = text_byte_in;

	// character classes, keyword narrowing and word resolution
	always_comb begin
		is_letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		is_digit  = (b >= "0" && b <= "9");
		is_space  = (b == " ") || (b >= 8'd9 && b <= 8'd13);
		is_op     = (b == "+") || (b == "-") || (b == "/") || (b == "*") ||
		            (b == "(") || (b == ")") || (b == ",");
		for (int i = 0; i < KwUsed; i++) begin
			narrow_cur[i]   = cand_q[i] && (wlen_q < KW_LEN[i]) &&
			                  (KW_TEXT[i][wlen_q] == b);
			narrow_first[i] = (KW_TEXT[i][0] == b);
		end
		fw_hit = 1'b0;
		fw_idx = '0;
		for (int i = KwUsed - 1; i >= 0; i--) begin
			if (cand_q[i] && KW_LEN[i] == wlen_q) begin
				fw_hit = 1'b1;
				fw_idx = 4'(i);
			end
		end
		fw_res = '{kind: fw_hit ? KW_CLASS[fw_idx] : KIND_UNKNOWN,
		           index: fw_hit ? fw_idx : 4'd0, lit: 8'd0};

		id_emit = 1'b0;
		id_halt = 1'b0;
		id_mode = MODE_IDLE;
		id_res  = '{kind: KIND_LITERAL, index: 4'd0, lit: b};
		if (is_space) begin
			id_mode = MODE_IDLE;
		end else if (is_letter) begin
			id_mode = MODE_WORD;
		end else if (is_digit) begin
			id_emit = 1'b1;
			id_mode = MODE_NUMBER;
		end else if (b == CHAR_QUOTE) begin
			id_mode = MODE_STRING;
		end else if (is_op) begin
			id_emit     = 1'b1;
			id_res.kind = KIND_OPERATOR;
		end else begin
			id_emit     = 1'b1;
			id_halt     = 1'b1;
			id_res.kind = KIND_BAD_SYMBOL;
		end

		cnt_line = line_q;
		cnt_col  = (col_q != COUNT_MAX) ? col_q + 16'd1 : col_q;
		if (b == CHAR_NL) begin
			cnt_line = (line_q != COUNT_MAX) ? line_q + 16'd1 : line_q;
			cnt_col  = '0;
		end
	end

	// plan what this beat does
	always_comb begin
		r0     = '0;
		r1     = '0;
		n      = 2'd0;
		halt   = 1'b0;
		wfirst = 1'b0;
		wnext  = 1'b0;
		flush  = 1'b0;
		mode_n = mode_q;
		if (end_of_text) begin
			case (mode_q)
				MODE_WORD: begin
					r0   = fw_res;
					n    = 2'd1;
					halt = !fw_hit;
				end
				MODE_NUMBER: begin
					r0.kind = KIND_NUMBER_END;
					n       = 2'd1;
				end
				MODE_STRING: begin
					r0.kind = KIND_UNTERM_STR;
					n       = 2'd1;
					halt    = 1'b1;
				end
				default: ;
			endcase
			flush  = !halt;
			mode_n = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_WORD: begin
					if (is_letter) begin
						wnext = 1'b1;
					end else if (fw_hit) begin
						r0     = fw_res;
						r1     = id_res;
						n      = 2'd1 + {1'b0, id_emit};
						halt   = id_halt;
						mode_n = id_mode;
						wfirst = is_letter;
					end else begin
						r0     = fw_res;
						n      = 2'd1;
						halt   = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (is_digit || b == CHAR_DOT) begin
						r0 = '{kind: KIND_LITERAL, index: 4'd0, lit: b};
						n  = 2'd1;
					end else begin
						r0.kind = KIND_NUMBER_END;
						r1      = id_res;
						n       = 2'd1 + {1'b0, id_emit};
						halt    = id_halt;
						mode_n  = id_mode;
						wfirst  = is_letter;
					end
				end
				MODE_STRING: begin
					n = 2'd1;
					if (b == CHAR_QUOTE) begin
						r0.kind = KIND_STRING_END;
						mode_n  = MODE_IDLE;
					end else begin
						r0 = '{kind: KIND_LITERAL, index: 4'd0, lit: b};
					end
				end
				default: begin
					r0     = id_res;
					n      = {1'b0, id_emit};
					halt   = id_halt;
					mode_n = id_mode;
					wfirst = is_letter;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d   = mode_q;
		cand_d   = cand_q;
		wlen_d   = wlen_q;
		line_d   = line_q;
		col_d    = col_q;
		halted_d = halted_q;
		if (accept && !halted_q) begin
			mode_d   = mode_n;
			halted_d = halt;
			if (flush) begin
				cand_d = '1;
				wlen_d = 3'd0;
				line_d = 16'd1;
				col_d  = 16'd1;
			end else begin
				if (!end_of_text) begin
					line_d = cnt_line;
					col_d  = cnt_col;
				end
				if (wfirst) begin
					cand_d = narrow_first;
					wlen_d = 3'd1;
				end
				if (wnext) begin
					cand_d = narrow_cur;
					wlen_d = (wlen_q != 3'd7) ? wlen_q + 3'd1 : wlen_q;
				end
			end
		end
	end

	// queue push
	always_comb begin
		push_valid       = accept && !halted_q && (n != 2'd0);
		push_entry.res_a = r0;
		push_entry.res_b = r1;
		push_entry.two   = (n == 2'd2);
		push_entry.line  = end_of_text ? line_q : cnt_line;
		push_entry.col   = end_of_text ? col_q : cnt_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			cand_q   <= '1;
			wlen_q   <= 3'd0;
			line_q   <= 16'd1;
			col_q    <= 16'd1;
			halted_q <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			cand_q   <= cand_d;
			wlen_q   <= wlen_d;
			line_q   <= line_d;
			col_q    <= col_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ----- rtl/core/slex_queue.sv -----
// Short entry queue between the lexer front and back ends.
// Uses slex_pkg for the entry type and depth.
module slex_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  slex_pkg::lex_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output slex_pkg::lex_entry_t pop_entry
);
	import slex_pkg::*;

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	lex_entry_t            slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0]       wr_q, rd_q;
	logic [CntW-1:0]       cnt_q;
	logic                  do_push, do_pop;

	assign full      = (cnt_q == CntW'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = slot_q[rd_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/slex_back.sv -----
// Back end of the script lexer: splits queue entries into single tokens and
// holds each in the output register until taken. Uses slex_pkg.
module slex_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  slex_pkg::lex_entry_t q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           token_kind,
	output logic [3:0]           keyword_index,
	output logic [7:0]           literal_byte,
	output logic [15:0]          line_number,
	output logic [15:0]          column_number,
	output logic                 last_of_run
);
	import slex_pkg::*;

	logic        out_valid_q, out_last_q;
	lex_result_t out_res_q;
	logic [15:0] out_line_q, out_col_q;
	logic        sec_pend_q;
	lex_result_t sec_res_q;
	logic [15:0] sec_line_q, sec_col_q;
	logic        load;

	assign load  = !out_valid_q || out_ready;
	assign q_pop = load && !sec_pend_q && q_valid;

	assign out_valid     = out_valid_q;
	assign token_kind    = out_res_q.kind;
	assign keyword_index = out_res_q.index;
	assign literal_byte  = out_res_q.lit;
	assign line_number   = out_line_q;
	assign column_number = out_col_q;
	assign last_of_run   = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_pend_q) begin
				out_res_q  <= sec_res_q;
				out_line_q <= sec_line_q;
				out_col_q  <= sec_col_q;
				out_last_q <= 1'b1;
			end else if (q_valid) begin
				out_res_q  <= q_entry.res_a;
				out_line_q <= q_entry.line;
				out_col_q  <= q_entry.col;
				out_last_q <= !q_entry.two;
				sec_res_q  <= q_entry.res_b;
				sec_line_q <= q_entry.line;
				sec_col_q  <= q_entry.col;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_pend_q  <= 1'b0;
		end else if (load) begin
			if (sec_pend_q) begin
				out_valid_q <= 1'b1;
				sec_pend_q  <= 1'b0;
			end else begin
				out_valid_q <= q_valid;
				sec_pend_q  <= q_valid && q_entry.two;
			end
		end
	end

endmodule

// ----- rtl/core/script_lexer.sv -----
// Script lexer top level: front end, entry queue and token back end.
// Depends on slex_pkg, slex_front, slex_queue and slex_back.
//
// The lexer takes one source byte per beat (or an end-of-text beat) and
// returns tokens: keyword index and class for letter runs, literal bytes for
// numbers and strings followed by a closing token, operator characters,
// and error tokens. It accepts a new byte every cycle while the queue is not
// full: the front end classifies the byte and updates mode, keyword mask and
// line/column in that same cycle, and pushes the one or two tokens the byte
// causes as a single entry into a four-deep queue. The back end drains that
// queue through an output register, one token per cycle while out_ready is
// high, so a byte that yields one token sustains one byte per cycle, and a
// byte that yields two (a keyword closed by a digit, an operator or a stray
// symbol, or a number closed by an operator or a stray symbol) puts both
// tokens through the output in turn; the queue absorbs the difference and
// short output stalls. A token enters a queue slot when its byte is accepted
// and then the output register. last_of_run marks the final token of each
// byte. After an error token (unknown word, bad symbol, unterminated string)
// the block still accepts beats but drops them, producing nothing until reset.
module script_lexer #(
	parameter int unsigned KEYWORD_COUNT = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte_in,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [3:0]  keyword_index,
	output logic [7:0]  literal_byte,
	output logic [15:0] line_number,
	output logic [15:0] column_number,
	output logic        last_of_run
);
	import slex_pkg::*;

	logic       push_valid, queue_full, q_valid, q_pop;
	lex_entry_t push_entry, q_entry;

	// classify bytes and track lexer state
	slex_front #(
		.KEYWORD_COUNT(KEYWORD_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte_in(text_byte_in),
		.end_of_text (end_of_text),
		.queue_full  (queue_full),
		.push_valid  (push_valid),
		.push_entry  (push_entry)
	);

	// decouple front and back so each may stall on its own
	slex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_entry (q_entry)
	);

	// serialize entries into single token beats
	slex_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.keyword_index(keyword_index),
		.literal_byte (literal_byte),
		.line_number  (line_number),
		.column_number(column_number),
		.last_of_run  (last_of_run)
	);

endmodule
